/* src/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the stack with linear search.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CountW   = 8;
  localparam int unsigned DefDepth = 128;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef struct packed {
    logic op_load;
    logic srch_start;
    logic srch_step;
    logic srch_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } dp_stat_t;

endpackage

/* src/sws_ram.sv */
// ----------------------------------------------------------------------------
// sws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int unsigned Width = sws_pkg::DataW,
  parameter int unsigned Depth = sws_pkg::DefDepth,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sws_ctrl.sv */
// ----------------------------------------------------------------------------
// sws_ctrl
// Controller: input and output handshake, search sequencing.
// ----------------------------------------------------------------------------
module sws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         command_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sws_pkg::dp_ctrl_t  ctrl_o,
  input  sws_pkg::dp_stat_t  stat_i
);

  import sws_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_busy;
  logic   accept;
  logic   is_search;
  logic   done;

  assign out_busy   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || out_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_search  = (cmd_e'(command_i) == CMD_SEARCH);
  assign done       = (state_q == S_SEARCH) && (stat_i.hit || stat_i.miss);

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.op_load    = accept && !is_search;
    ctrl_o.srch_start = accept && is_search;
    ctrl_o.srch_step  = (state_q == S_SEARCH);
    ctrl_o.srch_load  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && is_search) begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (done) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if ((accept && !is_search) || done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/sws_datapath.sv */
// ----------------------------------------------------------------------------
// sws_datapath
// Datapath: entry memory, fill count, search scan and result register.
// ----------------------------------------------------------------------------
module sws_datapath #(
  parameter int unsigned DEPTH = sws_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  command_i,
  input  logic signed [31:0]          operand_value_i,
  input  sws_pkg::dp_ctrl_t           ctrl_i,
  output sws_pkg::dp_stat_t           stat_o,
  output logic [1:0]                  status_o,
  output logic [sws_pkg::PosW-1:0]    found_position_o,
  output logic [sws_pkg::CountW-1:0]  entry_count_o
);

  import sws_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic [CntW-1:0]   scan_q;
  logic              pend_q;
  logic [AddrW-1:0]  pidx_q;
  logic [DataW-1:0]  key_q;
  status_e           res_status_q;
  logic [PosW-1:0]   res_pos_q;
  logic [CountW-1:0] res_count_q;

  status_e           op_status;
  logic              we;
  logic [DataW-1:0]  rdata;
  logic              issue;
  logic              hit;

  sws_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (operand_value_i),
    .raddr_i (scan_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // scan one entry per cycle, compare the word read in the previous cycle
  assign issue       = ctrl_i.srch_step && (scan_q < count_q);
  assign hit         = pend_q && (rdata == key_q);
  assign stat_o.hit  = ctrl_i.srch_step && hit;
  assign stat_o.miss = ctrl_i.srch_step && !hit && !issue;

  always_comb begin
    count_d   = count_q;
    op_status = ST_OK;
    we        = 1'b0;
    if (ctrl_i.op_load) begin
      unique case (cmd_e'(command_i))
        CMD_PUSH: begin
          if (count_q == CntW'(DEPTH)) begin
            op_status = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        CMD_POP: begin
          if (count_q == '0) begin
            op_status = ST_EMPTY;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        CMD_CLEAR: begin
          count_d = '0;
        end
        CMD_SEARCH: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (ctrl_i.srch_start) begin
        scan_q <= '0;
        pend_q <= 1'b0;
      end else if (ctrl_i.srch_step) begin
        if (issue) begin
          scan_q <= scan_q + CntW'(1);
        end
        pend_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.srch_start) begin
      key_q <= operand_value_i;
    end
    if (ctrl_i.srch_step) begin
      pidx_q <= scan_q[AddrW-1:0];
    end
    if (ctrl_i.op_load) begin
      res_status_q <= op_status;
      res_pos_q    <= '0;
      res_count_q  <= CountW'(count_d);
    end else if (ctrl_i.srch_load) begin
      res_status_q <= hit ? ST_OK : ST_MISS;
      res_pos_q    <= hit ? PosW'(pidx_q) : '0;
      res_count_q  <= CountW'(count_q);
    end
  end

  assign status_o         = res_status_q;
  assign found_position_o = res_pos_q;
  assign entry_count_o    = res_count_q;

endmodule

/* src/stack_with_search.sv */
// ----------------------------------------------------------------------------
// stack_with_search
// Bounded LIFO stack of 32-bit words with push, pop, clear and a linear
// search from the bottom. Push, pop and clear give their result in the
// cycle after the item is taken. A search reads the entry RAM through its
// single read port, one entry per cycle from the bottom, and its result
// appears once an entry matches or all entries on the stack have been read.
// One item is in work at a time; the next item is taken once the previous
// result has been shown and is not stalled.
// ----------------------------------------------------------------------------
module stack_with_search #(
  parameter int unsigned DEPTH = sws_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic signed [31:0]          operand_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [sws_pkg::PosW-1:0]    found_position_o,
  output logic [sws_pkg::CountW-1:0]  entry_count_o
);

  import sws_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  sws_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .command_i        (command_i),
    .operand_value_i  (operand_value_i),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

/* src/sws_checker.sv */
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks of the stack with search, bound to the top level.
// ----------------------------------------------------------------------------
module sws_checker #(
  parameter int unsigned DEPTH = sws_pkg::DefDepth
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [sws_pkg::PosW-1:0]    found_position_o,
  input logic [sws_pkg::CountW-1:0]  entry_count_o
);

  import sws_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(found_position_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // no new item while a result is stuck
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item taken while result stalled");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == CountW'(DEPTH))
    else $error("full reported below depth");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> entry_count_o == '0)
    else $error("empty reported with entries");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> found_position_o == '0)
    else $error("position set on failed item");

endmodule

bind stack_with_search sws_checker #(
  .DEPTH (DEPTH)
) u_sws_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .found_position_o (found_position_o),
  .entry_count_o    (entry_count_o)
);

/* tb/stack_with_search_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_search_tb
// Drives command items into the stack with search and checks every result
// against a local copy of the stack. A short directed sequence covers the
// value extremes, duplicates, stale popped slots and empty. A full-fill
// sequence and random segments with varying push/pop balance then run with
// bursts of idling and stalls on both sides.
// ----------------------------------------------------------------------------
module stack_with_search_tb;
  import sws_pkg::*;

  localparam int Depth     = DefDepth;
  localparam int NumItems  = 750;
  localparam int QuietTail = 100;
  localparam int StuckMax  = 2000;
  localparam int DrainWait = Depth + 20;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] value;
    bit          hold;
  } stack_item_t;

  typedef struct {
    status_e           status;
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] count;
  } stack_result_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i       = CMD_PUSH;
  logic signed [31:0]        operand_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic [1:0]                status_o;
  logic [PosW-1:0]           found_position_o;
  logic [CountW-1:0]         entry_count_o;

  stack_item_t   item_q[$];
  stack_result_t expected_q[$];

  logic [31:0] stack_words [Depth];
  int          stack_fill  = 0;
  logic [31:0] value_pool  [16];

  logic in_taken   = 1'b0;
  int   send_gap   = 0;
  int   stall_left = 0;
  int   stuck      = 0;
  int   mismatches = 0;
  int   results    = 0;
  int   n_push, n_full, n_pop, n_empty, n_search, n_hit, n_miss, n_clear, max_fill;

  stack_with_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .operand_value_i (operand_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic predict_stack_op(input cmd_e cmd, input logic [31:0] value,
                                  output stack_result_t res);
    int idx;
    res.status = ST_OK;
    res.pos    = '0;
    case (cmd)
      CMD_PUSH: begin
        n_push++;
        if (stack_fill >= Depth) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          stack_words[stack_fill] = value;
          stack_fill++;
        end
      end
      CMD_POP: begin
        n_pop++;
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          stack_fill--;
        end
      end
      CMD_SEARCH: begin
        n_search++;
        res.status = ST_MISS;
        for (idx = 0; idx < stack_fill; idx++) begin
          if (stack_words[idx] == value) begin
            res.status = ST_OK;
            res.pos    = idx[PosW-1:0];
            break;
          end
        end
        if (res.status == ST_OK) n_hit++;
        else n_miss++;
      end
      default: begin
        n_clear++;
        stack_fill = 0;
      end
    endcase
    if (stack_fill > max_fill) max_fill = stack_fill;
    res.count = stack_fill[CountW-1:0];
  endtask

  task automatic add_item(input cmd_e cmd, input logic [31:0] value, input bit hold);
    stack_item_t it;
    it.cmd   = cmd;
    it.value = value;
    it.hold  = hold;
    item_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // input driver
  always @(negedge clk_i) begin
    stack_item_t nxt;
    logic        drive;
    if (rst_ni) begin
      drive = in_valid_i && !in_taken;
      if (!drive) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (item_q.size() > 0 && !(item_q[0].hold && expected_q.size() > 0)) begin
          if (item_q.size() > QuietTail && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 9);
          end else begin
            nxt = item_q.pop_front();
            command_i       <= nxt.cmd;
            operand_value_i <= nxt.value;
            drive = 1'b1;
          end
        end
      end
      in_valid_i <= drive;
    end
  end

  // result stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (item_q.size() > QuietTail && $urandom_range(0, 5) == 0) begin
        stall_left  <= $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    stack_result_t exp_res;
    stack_result_t new_res;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d position %0d count %0d",
                     status_o, found_position_o, entry_count_o);
        end else begin
          exp_res = expected_q.pop_front();
          if (status_o !== exp_res.status || found_position_o !== exp_res.pos ||
              entry_count_o !== exp_res.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: status %0d/%0d position %0d/%0d count %0d/%0d",
                       results, exp_res.status, status_o, exp_res.pos, found_position_o,
                       exp_res.count, entry_count_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_stack_op(cmd_e'(command_i), operand_value_i, new_res);
        expected_q.push_back(new_res);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
      if (stuck >= StuckMax) begin
        $display("watchdog: no item moved for %0d cycles", StuckMax);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int          seg_len;
    int          push_w;
    int          roll;
    int          k;
    bit          mid_hold;
    logic [31:0] top_val;

    n_push = 0; n_full = 0; n_pop = 0; n_empty = 0;
    n_search = 0; n_hit = 0; n_miss = 0; n_clear = 0; max_fill = 0;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (k = 4; k < 16; k++) value_pool[k] = $urandom;

    // directed: empty stack, extremes, duplicates, stale slots, clear
    add_item(CMD_POP,    32'h0000_0000, 1'b0);
    add_item(CMD_SEARCH, 32'h0000_0000, 1'b0);
    add_item(CMD_PUSH,   32'h8000_0000, 1'b0);
    add_item(CMD_PUSH,   32'h7fff_ffff, 1'b0);
    add_item(CMD_PUSH,   32'h0000_0000, 1'b0);
    add_item(CMD_PUSH,   32'hffff_ffff, 1'b0);
    add_item(CMD_PUSH,   32'h8000_0000, 1'b0);
    add_item(CMD_SEARCH, 32'h8000_0000, 1'b0);
    add_item(CMD_SEARCH, 32'hffff_ffff, 1'b0);
    add_item(CMD_SEARCH, 32'h7fff_ffff, 1'b0);
    add_item(CMD_SEARCH, 32'h0000_0001, 1'b0);
    add_item(CMD_POP,    32'hffff_ffff, 1'b0);
    add_item(CMD_POP,    32'h0000_0000, 1'b0);
    add_item(CMD_SEARCH, 32'hffff_ffff, 1'b0);
    add_item(CMD_SEARCH, 32'h0000_0000, 1'b0);
    add_item(CMD_CLEAR,  32'h5555_aaaa, 1'b0);
    add_item(CMD_SEARCH, 32'h8000_0000, 1'b0);
    add_item(CMD_POP,    32'haaaa_5555, 1'b0);
    add_item(CMD_PUSH,   32'h0000_0005, 1'b0);
    add_item(CMD_CLEAR,  32'hffff_ffff, 1'b0);
    add_item(CMD_POP,    32'h0000_0000, 1'b0);

    // fill to the top after a full drain, then push past full
    top_val = '0;
    for (k = 0; k < Depth; k++) begin
      top_val = $urandom;
      add_item(CMD_PUSH, top_val, k == 0);
    end
    add_item(CMD_PUSH,   $urandom, 1'b0);
    add_item(CMD_PUSH,   value_pool[0], 1'b0);
    add_item(CMD_SEARCH, top_val, 1'b0);
    add_item(CMD_SEARCH, $urandom, 1'b0);
    add_item(CMD_POP,    $urandom, 1'b0);
    add_item(CMD_PUSH,   value_pool[1], 1'b0);
    add_item(CMD_SEARCH, value_pool[1], 1'b0);
    add_item(CMD_CLEAR,  $urandom, 1'b0);

    // random segments with a varying push/pop balance
    mid_hold = 1'b0;
    while (item_q.size() < NumItems) begin
      seg_len = $urandom_range(15, 60);
      case ($urandom_range(0, 3))
        0:       push_w = 30;
        1:       push_w = 55;
        2:       push_w = 80;
        default: push_w = 95;
      endcase
      for (k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2)
          add_item(CMD_CLEAR, $urandom, 1'b0);
        else if (roll < 38)
          add_item(CMD_SEARCH, pick_value(75), 1'b0);
        else if ($urandom_range(0, 99) < push_w)
          add_item(CMD_PUSH, pick_value(70), !mid_hold && item_q.size() > 400);
        else
          add_item(CMD_POP, $urandom, 1'b0);
        if (item_q.size() > 401) mid_hold = 1'b1;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (item_q.size() > 0 || in_valid_i || expected_q.size() > 0);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d pushes (%0d full), %0d pops (%0d empty), %0d clears",
             n_push, n_full, n_pop, n_empty, n_clear);
    $display("and %0d searches (%0d hits, %0d misses); deepest fill %0d of %0d",
             n_search, n_hit, n_miss, max_fill, Depth);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
